// ===== src/opwe_pkg.sv =====
// ----------------------------------------------------------------------------
// opwe_pkg - shared definitions for the pixel write engine
// Geometry constants, result codes and the job record passed front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package opwe_pkg;

    // Frame geometry
    localparam int PAGE_WIDTH  = 128;
    localparam int FRAME_BYTES = 1024;
    localparam int FRAME_LAST  = FRAME_BYTES - 1;

    // Shadow frame address and the wider raw index (page up to 15, px up to 255)
    localparam int ADDR_W = $clog2(FRAME_BYTES);
    localparam int IDX_W  = $clog2(15 * PAGE_WIDTH + 256);

    // Job queue depth
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes
    localparam logic [1:0] REG_DISPLAY_TYPE = 2'd0;
    localparam logic [1:0] REG_FLIPPED      = 2'd1;
    localparam logic [1:0] REG_READY        = 2'd2;

    // Display types
    localparam logic [1:0] DISP_128X64   = 2'd0;
    localparam logic [1:0] DISP_128X32   = 2'd1;
    localparam logic [1:0] DISP_64X32_C  = 2'd2;
    localparam logic [1:0] DISP_132X64   = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_CMD    = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_WRITTEN   = 2'd0;
    localparam logic [1:0] STAT_UNCHANGED = 2'd1;
    localparam logic [1:0] STAT_OFFSCREEN = 2'd2;
    localparam logic [1:0] STAT_NOTREADY  = 2'd3;

    // Controller command bases
    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [3:0] CMD_COL_HI    = 4'h1;
    localparam logic [3:0] CMD_COL_LO    = 4'h0;

    // Column and page offsets
    localparam logic [8:0] COL_OFS_CENTER = 9'd32;
    localparam logic [8:0] COL_OFS_WIDE   = 9'd2;
    localparam logic [4:0] PAGE_OFS_CENTER = 5'd4;

    // One classified pixel write
    typedef struct packed {
        logic              ok;        // needs a shadow lookup
        logic [1:0]        status;    // final status when not ok
        logic [ADDR_W-1:0] addr;
        logic [2:0]        bit_sel;
        logic              color;
        logic [7:0]        page_cmd;
        logic [7:0]        col;
    } job_t;

endpackage

`default_nettype wire

// ===== src/opwe_front.sv =====
// ----------------------------------------------------------------------------
// opwe_front - configuration registers and pixel write classification
// Checks readiness and range, works out the shadow address and the
// positioning bytes, and pushes one job per accepted item.
// ----------------------------------------------------------------------------
`default_nettype none

module opwe_front
    import opwe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       busy,
    input  wire logic [7:0] px,
    input  wire logic [6:0] py,
    input  wire logic       color,
    input  wire logic       cfg_wen,
    input  wire logic [1:0] cfg_index,
    input  wire logic [1:0] cfg_wdata,
    output logic            push,
    output job_t            job
);

    logic [1:0] display_type_reg;
    logic       flipped_reg;
    logic       ready_reg;

    logic [3:0]       page;
    logic [4:0]       page_pos;
    logic [IDX_W-1:0] idx;
    logic [8:0]       col_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_type_reg <= DISP_128X64;
            flipped_reg      <= 1'b0;
            ready_reg        <= 1'b0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_DISPLAY_TYPE: display_type_reg <= cfg_wdata;
                REG_FLIPPED:      flipped_reg      <= cfg_wdata[0];
                REG_READY:        ready_reg        <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        page     = py[6:3];
        idx      = IDX_W'(page) * IDX_W'(PAGE_WIDTH) + IDX_W'(px);
        page_pos = {1'b0, page};
        col_pos  = {1'b0, px};
        case (display_type_reg)
            DISP_64X32_C:
            begin
                col_pos = col_pos + COL_OFS_CENTER;
                if (!flipped_reg)
                    page_pos = page_pos + PAGE_OFS_CENTER;
            end
            DISP_132X64: col_pos = col_pos + COL_OFS_WIDE;
            default:     ;
        endcase

        job.ok       = 1'b0;
        job.status   = STAT_WRITTEN;
        job.addr     = idx[ADDR_W-1:0];
        job.bit_sel  = py[2:0];
        job.color    = color;
        job.page_cmd = CMD_PAGE_BASE | {3'b000, page_pos};
        job.col      = col_pos[7:0];
        if (!ready_reg)
            job.status = STAT_NOTREADY;
        else if (idx > IDX_W'(FRAME_LAST))
            job.status = STAT_OFFSCREEN;
        else
            job.ok = 1'b1;
    end

    assign push = start && !busy;

endmodule

`default_nettype wire

// ===== src/opwe_queue.sv =====
// ----------------------------------------------------------------------------
// opwe_queue - short job queue between front and back
// Register-based FIFO of classified jobs; head is shown while not empty.
// ----------------------------------------------------------------------------
`default_nettype none

module opwe_queue
    import opwe_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output logic      head_valid,
    output job_t      head_job,
    output logic      full
);

    job_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

// ===== src/opwe_back.sv =====
// ----------------------------------------------------------------------------
// opwe_back - shadow frame owner and result sequencer
// Clears the shadow after reset, looks up and updates bytes, and emits the
// command and data bytes one per cycle and the status results through registered outputs.
// ----------------------------------------------------------------------------
`default_nettype none

module opwe_back
    import opwe_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic head_valid,
    input  wire job_t head_job,
    output logic      pop,
    output logic      clearing,
    output logic       strobe,
    output logic [1:0] kind,
    output logic [7:0] byte_value,
    output logic [1:0] status,
    output logic       last
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_LO    = 3'd3;
    localparam logic [2:0] S_HI    = 3'd4;
    localparam logic [2:0] S_DATA  = 3'd5;

    logic [7:0] mem [FRAME_BYTES];

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    job_t              job_reg;
    job_t              job_next;
    logic [7:0]        new_byte_reg;
    logic [7:0]        new_byte_next;
    logic [7:0]        rdata_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [7:0]        mask;
    logic [7:0]        merged;

    logic       strobe_reg;
    logic       strobe_next;
    logic [1:0] kind_reg;
    logic [1:0] kind_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic [1:0] status_reg;
    logic [1:0] status_next;
    logic       last_reg;
    logic       last_next;

    always_comb
    begin
        mask   = 8'b1 << job_reg.bit_sel;
        merged = job_reg.color ? (rdata_reg | mask) : (rdata_reg & ~mask);
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        job_next      = job_reg;
        new_byte_next = new_byte_reg;
        pop           = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = job_reg.addr;
        mem_wdata     = new_byte_reg;
        mem_re        = 1'b0;
        strobe_next   = 1'b0;
        kind_next     = KIND_STATUS;
        byte_next     = 8'h00;
        status_next   = STAT_WRITTEN;
        last_next     = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = 8'h00;
                if (clr_addr_reg == ADDR_W'(FRAME_LAST))
                    state_next = S_IDLE;
                else
                    clr_addr_next = clr_addr_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    if (head_job.ok)
                    begin
                        mem_re     = 1'b1;
                        job_next   = head_job;
                        state_next = S_CMP;
                    end
                    else
                    begin
                        // status-only job: single result
                        strobe_next = 1'b1;
                        kind_next   = KIND_STATUS;
                        status_next = head_job.status;
                        last_next   = 1'b1;
                    end
                end
            end
            S_CMP:
            begin
                strobe_next = 1'b1;
                if (merged == rdata_reg)
                begin
                    kind_next   = KIND_STATUS;
                    status_next = STAT_UNCHANGED;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    // commit the byte now so a following lookup sees it
                    mem_we        = 1'b1;
                    mem_wdata     = merged;
                    new_byte_next = merged;
                    kind_next     = KIND_CMD;
                    byte_next     = job_reg.page_cmd;
                    state_next    = S_LO;
                end
            end
            S_LO:
            begin
                strobe_next = 1'b1;
                kind_next   = KIND_CMD;
                byte_next   = {CMD_COL_LO, job_reg.col[3:0]};
                state_next  = S_HI;
            end
            S_HI:
            begin
                strobe_next = 1'b1;
                kind_next   = KIND_CMD;
                byte_next   = {CMD_COL_HI, job_reg.col[7:4]};
                state_next  = S_DATA;
            end
            S_DATA:
            begin
                strobe_next = 1'b1;
                kind_next   = KIND_DATA;
                byte_next   = new_byte_reg;
                last_next   = 1'b1;
                state_next  = S_IDLE;
                // overlap the next lookup with the data byte
                if (head_valid && head_job.ok)
                begin
                    pop        = 1'b1;
                    mem_re     = 1'b1;
                    job_next   = head_job;
                    state_next = S_CMP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        new_byte_reg <= new_byte_next;
        kind_reg     <= kind_next;
        byte_reg     <= byte_next;
        status_reg   <= status_next;
        last_reg     <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[head_job.addr];
    end

    assign clearing   = (state_reg == S_CLEAR);
    assign strobe     = strobe_reg;
    assign kind       = kind_reg;
    assign byte_value = byte_reg;
    assign status     = status_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

// ===== src/oled_pixel_write_engine_core.sv =====
// ----------------------------------------------------------------------------
// oled_pixel_write_engine_core - page-mode display pixel write engine
// Keeps a shadow of a page-mode monochrome frame and turns pixel writes into
// controller command and data bytes.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------
//   pixel in | start & !busy        | px[7:0], py[6:0], color
//   result   | strobe (one cycle)   | kind[1:0], byte_value[7:0], status, last
//   config   | cfg_wen              | cfg_index[1:0], cfg_wdata[1:0]
//
// After reset a clearing pass zeroes the shadow frame, one byte a cycle across all
// 1024 bytes, with busy held high; configuration writes are taken meanwhile.
// A pixel that changes its byte gives four results on consecutive cycles; the
// lookup for a queued next such write overlaps the data byte of the one before,
// and the queue takes new items meanwhile. An accepted item passes the queue and
// the registered result outputs, a shadow lookup also the read register. Status-only
// items give a single result. Items queue in a 2-entry job queue; busy rises only
// while it is full or during the clearing pass. The receiver cannot stall: each
// result shows for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module oled_pixel_write_engine_core
    import opwe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // pixel write command
    input  wire logic       start,
    output logic            busy,
    input  wire logic [7:0] px,
    input  wire logic [6:0] py,
    input  wire logic       color,
    // configuration write port
    input  wire logic       cfg_wen,
    input  wire logic [1:0] cfg_index,
    input  wire logic [1:0] cfg_wdata,
    // result stream
    output logic            strobe,
    output logic [1:0]      kind,
    output logic [7:0]      byte_value,
    output logic [1:0]      status,
    output logic            last
);

    // front to queue
    logic push;
    job_t push_job;

    // queue to back
    logic head_valid;
    job_t head_job;
    logic pop;
    logic full;

    logic clearing;

    // hold off new items while the shadow is being cleared or the queue is full
    assign busy = clearing || full;

    // classify the pixel write and keep the configuration registers
    opwe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .px        (px),
        .py        (py),
        .color     (color),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .job       (push_job)
    );

    // decouple acceptance from byte emission
    opwe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job),
        .full       (full)
    );

    // look up the shadow byte, transfer the results, update the shadow
    opwe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .clearing   (clearing),
        .strobe     (strobe),
        .kind       (kind),
        .byte_value (byte_value),
        .status     (status),
        .last       (last)
    );

endmodule

`default_nettype wire

// ===== src/opwe_checker.sv =====
// ----------------------------------------------------------------------------
// opwe_checker - port-level checks for the pixel write engine
// Watches the result stream for well-formed byte sequences.
// ----------------------------------------------------------------------------
`default_nettype none

module opwe_checker
    import opwe_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       strobe,
    input wire logic [1:0] kind,
    input wire logic [7:0] byte_value,
    input wire logic [1:0] status,
    input wire logic       last
);

    // status-only results end their item and carry no byte
    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && kind == KIND_STATUS |-> last && byte_value == 8'h00)
        else $error("status-only result malformed");

    // a data byte closes a written item
    a_data_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && kind == KIND_DATA |-> last && status == STAT_WRITTEN)
        else $error("data byte not final or not written");

    // a page command is followed by the low column command
    a_page_then_low: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && kind == KIND_CMD && byte_value[7:4] == CMD_PAGE_BASE[7:4] |=>
        strobe && kind == KIND_CMD && byte_value[7:4] == CMD_COL_LO)
        else $error("page command not followed by low column");

    // the high column command is followed by the data byte
    a_high_then_data: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && kind == KIND_CMD && byte_value[7:4] == CMD_COL_HI |=>
        strobe && kind == KIND_DATA)
        else $error("high column not followed by data");

endmodule

bind oled_pixel_write_engine_core opwe_checker u_opwe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .strobe     (strobe),
    .kind       (kind),
    .byte_value (byte_value),
    .status     (status),
    .last       (last)
);

`default_nettype wire

// ===== tb/sv/oled_pixel_write_engine_core_test.sv =====
// ----------------------------------------------------------------------------
// oled_pixel_write_engine_core_test - self-checking bench for the pixel engine
// Drives pixel writes through the start/busy command port and predicts, per
// transfer, the controller byte stream from a private copy of the shadow frame
// and the register settings. Each strobed result is checked field by field
// against the oldest predicted byte. Register settings change between phases
// only once the engine has gone quiet.
// ----------------------------------------------------------------------------
`default_nettype none

module oled_pixel_write_engine_core_test;
    import opwe_pkg::*;

    localparam int LIMIT_CYCLES   = 200000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_ITEMS    = 52;
    localparam int N_PHASES       = 8;

    // One pending pixel write and the idle cycles that precede it
    typedef struct {
        logic [7:0] x;
        logic [6:0] y;
        logic       c;
        int         gap;
    } pixel_req_t;

    // One byte (or status word) expected on the result port
    typedef struct {
        logic [1:0] kind;
        logic [7:0] value;
        logic [1:0] status;
        logic       last;
    } link_byte_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [7:0] px;
    logic [6:0] py;
    logic       color;
    logic       cfg_wen;
    logic [1:0] cfg_index;
    logic [1:0] cfg_wdata;
    logic       strobe;
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic [1:0] status;
    logic       last;

    // Private copy of the engine state
    logic [7:0] frame_copy [0:FRAME_BYTES-1];
    logic [1:0] dtype_m;
    logic       flip_m;
    logic       ready_m;

    pixel_req_t pixel_q [$];
    link_byte_t link_bytes_due [$];

    // Driver bookkeeping
    pixel_req_t next_req;
    logic       have_next;
    int         wait_cnt;
    logic       xfer_seen;

    int n_errors;
    int n_taken;
    int n_results;
    int n_settings;
    int cycle_count;
    int stat_seen [0:3];

    oled_pixel_write_engine_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .px         (px),
        .py         (py),
        .color      (color),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .strobe     (strobe),
        .kind       (kind),
        .byte_value (byte_value),
        .status     (status),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Byte stream prediction
    // ------------------------------------------------------------------------
    function automatic void push_link_byte(input logic [1:0] k, input logic [7:0] v,
                                           input logic [1:0] s, input logic l);
        link_byte_t b;
        b.kind   = k;
        b.value  = v;
        b.status = s;
        b.last   = l;
        link_bytes_due.push_back(b);
    endfunction

    // Work out the bytes one accepted pixel write sends and update the copy
    function automatic void predict_pixel_bytes(input logic [7:0] x, input logic [6:0] y,
                                                input logic c);
        logic [4:0] page;
        logic [8:0] col;
        logic [7:0] old_b;
        logic [7:0] new_b;
        logic [7:0] mask;
        int         idx;
        page = {1'b0, y[6:3]};
        idx  = int'(page) * PAGE_WIDTH + int'(x);
        // readiness is checked ahead of the frame bounds
        if (!ready_m)
            push_link_byte(KIND_STATUS, 8'h00, STAT_NOTREADY, 1'b1);
        else if (idx > FRAME_BYTES - 1)
            push_link_byte(KIND_STATUS, 8'h00, STAT_OFFSCREEN, 1'b1);
        else
        begin
            old_b = frame_copy[idx];
            mask  = 8'h01 << y[2:0];
            new_b = c ? (old_b | mask) : (old_b & ~mask);
            if (new_b == old_b)
                push_link_byte(KIND_STATUS, 8'h00, STAT_UNCHANGED, 1'b1);
            else
            begin
                // position the controller: the centered panel shifts the
                // column, and the page too unless rotated; the wide controller
                // shifts the column by two
                col = {1'b0, x};
                if (dtype_m == DISP_64X32_C)
                begin
                    col = col + 9'd32;
                    if (!flip_m)
                        page = page + 5'd4;
                end
                else if (dtype_m == DISP_132X64)
                    col = col + 9'd2;
                push_link_byte(KIND_CMD, CMD_PAGE_BASE | {3'b000, page},
                               STAT_WRITTEN, 1'b0);
                push_link_byte(KIND_CMD, {CMD_COL_LO, col[3:0]}, STAT_WRITTEN, 1'b0);
                push_link_byte(KIND_CMD, {CMD_COL_HI, col[7:4]}, STAT_WRITTEN, 1'b0);
                push_link_byte(KIND_DATA, new_b, STAT_WRITTEN, 1'b1);
                frame_copy[idx] = new_b;
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: check results, then predict for the transfer taken this edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        link_byte_t want;
        if (!rst_n)
            xfer_seen <= 1'b0;
        else
        begin
            if (strobe === 1'b1)
            begin
                n_results++;
                if (last === 1'b1 && !$isunknown(status))
                    stat_seen[status]++;
                if (link_bytes_due.size() == 0)
                begin
                    $error("unexpected result: kind %0d byte %02h status %0d last %0d",
                           kind, byte_value, status, last);
                    n_errors++;
                end
                else
                begin
                    want = link_bytes_due.pop_front();
                    if (kind !== want.kind)
                    begin
                        $error("kind mismatch: expected %0d, actual %0d", want.kind, kind);
                        n_errors++;
                    end
                    if (byte_value !== want.value)
                    begin
                        $error("byte_value mismatch: expected %02h, actual %02h",
                               want.value, byte_value);
                        n_errors++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, status);
                        n_errors++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last mismatch: expected %0d, actual %0d", want.last, last);
                        n_errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                predict_pixel_bytes(px, py, color);
                n_taken++;
            end
            xfer_seen <= start && !busy;
        end
    end

    // ------------------------------------------------------------------------
    // Driver: hold start until the transfer is taken, then idle for the next
    // item's gap or present it right away
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : pixel_driver
        if (rst_n && (!start || xfer_seen))
        begin
            if (!have_next && pixel_q.size() > 0)
            begin
                next_req  = pixel_q.pop_front();
                have_next = 1'b1;
                wait_cnt  = next_req.gap;
            end
            if (have_next && wait_cnt == 0)
            begin
                start     <= 1'b1;
                px        <= next_req.x;
                py        <= next_req.y;
                color     <= next_req.c;
                have_next = 1'b0;
            end
            else
            begin
                if (have_next)
                    wait_cnt--;
                start <= 1'b0;
            end
        end
    end

    // Watchdog: the clearing pass plus every item at its slowest fits well inside
    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $error("timeout after %0d cycles, %0d results still due",
                   cycle_count, link_bytes_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int draw_gap(input logic burst);
        if (burst)
            return 0;
        return $urandom_range(0, 10);
    endfunction

    function automatic void add_pixel(input logic [7:0] x, input logic [6:0] y,
                                      input logic c, input logic burst);
        pixel_req_t r;
        r.x   = x;
        r.y   = y;
        r.c   = c;
        r.gap = draw_gap(burst);
        pixel_q.push_back(r);
    endfunction

    // Mostly in-frame writes, many in a small corner so pixels get revisited
    // and unchanged writes show up; the rest hit columns past the page and
    // rows below the frame
    function automatic void add_random_pixel(input logic burst);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            add_pixel(8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                      1'($urandom_range(0, 1)), burst);
        else if (sel == 1)
            add_pixel(8'($urandom_range(128, 255)), 7'($urandom_range(0, 55)),
                      1'($urandom_range(0, 1)), burst);
        else if (sel <= 5)
            add_pixel(8'($urandom_range(0, 7)), 7'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)), burst);
        else
            add_pixel(8'($urandom_range(0, 127)), 7'($urandom_range(0, 63)),
                      1'($urandom_range(0, 1)), burst);
    endfunction

    // Wait until nothing is pending or due, then let the engine settle
    task automatic wait_quiet();
        while (pixel_q.size() != 0 || have_next || start || link_bytes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all three registers, one per cycle
    task automatic set_config(input logic [1:0] dtype, input logic flip, input logic rdy);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= REG_DISPLAY_TYPE;
        cfg_wdata <= dtype;
        @(negedge clk);
        cfg_index <= REG_FLIPPED;
        cfg_wdata <= {1'b0, flip};
        @(negedge clk);
        cfg_index <= REG_READY;
        cfg_wdata <= {1'b0, rdy};
        @(negedge clk);
        cfg_wen   <= 1'b0;
        dtype_m = dtype;
        flip_m  = flip;
        ready_m = rdy;
        n_settings++;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : test_seq
        logic [1:0] ph_dtype [0:N_PHASES-1];
        logic       ph_flip  [0:N_PHASES-1];
        logic       ph_ready [0:N_PHASES-1];
        logic       burst;
        ph_dtype = '{DISP_128X32, DISP_64X32_C, DISP_64X32_C, DISP_132X64,
                     DISP_132X64, DISP_128X64, DISP_128X32, DISP_128X64};
        ph_flip  = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
        ph_ready = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};

        rst_n      = 1'b0;
        start      = 1'b0;
        px         = '0;
        py         = '0;
        color      = 1'b0;
        cfg_wen    = 1'b0;
        cfg_index  = REG_DISPLAY_TYPE;
        cfg_wdata  = '0;
        dtype_m    = DISP_128X64;
        flip_m     = 1'b0;
        ready_m    = 1'b0;
        have_next  = 1'b0;
        wait_cnt   = 0;
        n_errors   = 0;
        n_taken    = 0;
        n_results  = 0;
        n_settings = 0;
        cycle_count = 0;
        foreach (stat_seen[i])
            stat_seen[i] = 0;
        foreach (frame_copy[i])
            frame_copy[i] = 8'h00;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Link closed: everything is refused, even rows below the frame
        set_config(DISP_128X64, 1'b0, 1'b0);
        add_pixel(8'd0,   7'd0,   1'b1, 1'b0);
        add_pixel(8'd255, 7'd127, 1'b0, 1'b0);
        add_pixel(8'd64,  7'd33,  1'b1, 1'b1);
        wait_quiet();

        // Link open: set/clear, repeats, frame corners and aliased columns
        set_config(DISP_128X64, 1'b0, 1'b1);
        add_pixel(8'd0,   7'd0,   1'b1, 1'b0);   // set first pixel
        add_pixel(8'd0,   7'd0,   1'b1, 1'b1);   // same again: unchanged
        add_pixel(8'd0,   7'd0,   1'b0, 1'b1);   // clear it
        add_pixel(8'd0,   7'd0,   1'b0, 1'b0);   // clear again: unchanged
        add_pixel(8'd10,  7'd10,  1'b0, 1'b0);   // clear a dark pixel
        add_pixel(8'd127, 7'd63,  1'b1, 1'b1);   // last byte of the frame
        add_pixel(8'd128, 7'd56,  1'b1, 1'b1);   // one past the frame
        add_pixel(8'd255, 7'd0,   1'b1, 1'b0);   // column past the page
        add_pixel(8'd255, 7'd48,  1'b1, 1'b1);   // aliases the last byte
        add_pixel(8'd255, 7'd127, 1'b1, 1'b0);   // every field at its top
        add_pixel(8'd0,   7'd64,  1'b1, 1'b1);   // first row below the frame
        add_pixel(8'd5,   7'd7,   1'b1, 1'b1);   // top bit of a byte
        add_pixel(8'd5,   7'd0,   1'b1, 1'b1);   // bottom bit of the same byte
        add_pixel(8'd5,   7'd7,   1'b0, 1'b0);
        add_pixel(8'd170, 7'd85,  1'b0, 1'b0);
        add_pixel(8'd85,  7'd42,  1'b1, 1'b1);
        wait_quiet();

        // Random phases across the register settings; every third one
        // runs back to back with no idle cycles
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            burst = (ph % 3 == 1);
            set_config(ph_dtype[ph], ph_flip[ph], ph_ready[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++)
                add_random_pixel(burst);
            wait_quiet();
        end

        $display("Covered %0d pixel writes under %0d register settings, %0d result bytes",
                 n_taken, n_settings, n_results);
        $display("Outcomes: written %0d, unchanged %0d, off screen %0d, not ready %0d",
                 stat_seen[STAT_WRITTEN], stat_seen[STAT_UNCHANGED],
                 stat_seen[STAT_OFFSCREEN], stat_seen[STAT_NOTREADY]);
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
src/opwe_pkg.sv
src/opwe_front.sv
src/opwe_queue.sv
src/opwe_back.sv
src/oled_pixel_write_engine_core.sv
src/opwe_checker.sv
tb/sv/oled_pixel_write_engine_core_test.sv
